### rtl/usan_pkg.sv
// Shared types, constants and helper functions for the UTF-8 sanitiser.
package usan_pkg;

  // Replacement character U+FFFD in UTF-8.
  localparam logic [7:0] REP_BYTE0 = 8'hEF;
  localparam logic [7:0] REP_BYTE1 = 8'hBF;
  localparam logic [7:0] REP_BYTE2 = 8'hBD;

  // Lead byte masks and patterns.
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_PAT  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_PAT  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_PAT  = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_PAT   = 8'h80;

  // Number of held bytes of an open sequence.
  localparam int unsigned HELD_DEPTH = 3;

  // Emitter sequencer states.
  typedef enum logic {
    EM_IDLE,
    EM_RUN
  } em_state_t;

  // Emission plan for one request: replacements first, then held bytes, then the tail byte.
  typedef struct packed {
    logic [2:0]      rep_n;
    logic [1:0]      held_n;
    logic [2:0][7:0] held;
    logic            tail;
    logic [7:0]      tail_byte;
    logic            eos;
  } usan_plan_t;

  // Sequence length announced by a lead byte, zero if it is not a lead byte.
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if ((b & LEAD2_MASK) == LEAD2_PAT) begin
      len = 3'd2;
    end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
      len = 3'd3;
    end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
      len = 3'd4;
    end
    return len;
  endfunction

  // Byte of the replacement character at the given position.
  function automatic logic [7:0] rep_byte(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = REP_BYTE0;
      2'd1:    b = REP_BYTE1;
      default: b = REP_BYTE2;
    endcase
    return b;
  endfunction

endpackage

### rtl/usan_if.sv
// Stream interfaces for the raw input bytes and the sanitised output bytes.
interface usan_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface usan_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       stream_done;

  modport source (output valid, output out_byte, output last_of_run, output stream_done,
                  input ready);
  modport sink   (input valid, input out_byte, input last_of_run, input stream_done,
                  output ready);
endinterface

### rtl/usan_ctrl.sv
// Sequence tracker: holds the open sequence and turns each request into an emission plan.
module usan_ctrl
  import usan_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_stream,
  output usan_plan_t plan
);

  logic [7:0] pend_r [HELD_DEPTH];
  logic [1:0] cnt_r, cnt_nxt;
  logic [2:0] need_r, need_nxt;

  logic       open_seq;
  logic       is_cont;
  logic       is_ascii;
  logic [2:0] len;
  logic       fresh_rep;
  logic       fresh_store;
  logic       wr_en;
  logic [1:0] wr_idx;

  // Classify the incoming byte against the open sequence.
  always_comb begin
    open_seq    = (cnt_r != 2'd0) && (need_r >= 3'd2) && (need_r <= 3'd4);
    is_cont     = (data_byte & CONT_MASK) == CONT_PAT;
    is_ascii    = !data_byte[7];
    len         = lead_length(data_byte);
    fresh_rep   = !is_ascii && ((len == 3'd0) || end_of_stream);
    fresh_store = !is_ascii && (len != 3'd0) && !end_of_stream;
  end

  // Build the plan and the next sequence state.
  always_comb begin
    plan.rep_n     = 3'd0;
    plan.held_n    = 2'd0;
    plan.held      = {pend_r[2], pend_r[1], pend_r[0]};
    plan.tail      = 1'b0;
    plan.tail_byte = data_byte;
    plan.eos       = end_of_stream;
    cnt_nxt        = 2'd0;
    need_nxt       = 3'd0;
    wr_en          = 1'b0;
    wr_idx         = 2'd0;
    if (!open_seq) begin
      plan.rep_n = {2'b00, fresh_rep};
      plan.tail  = is_ascii;
      if (fresh_store) begin
        wr_en    = 1'b1;
        cnt_nxt  = 2'd1;
        need_nxt = len;
      end
    end else if (is_cont) begin
      if (({1'b0, cnt_r} + 3'd1) >= need_r) begin
        plan.held_n = cnt_r;
        plan.tail   = 1'b1;
      end else if (end_of_stream) begin
        plan.rep_n = 3'd1;
      end else begin
        wr_en    = 1'b1;
        wr_idx   = cnt_r;
        cnt_nxt  = cnt_r + 2'd1;
        need_nxt = need_r;
      end
    end else begin
      // Lead byte and each held continuation byte become replacements, then a fresh start.
      plan.rep_n = {1'b0, cnt_r} + {2'b00, fresh_rep};
      plan.tail  = is_ascii;
      if (fresh_store) begin
        wr_en    = 1'b1;
        cnt_nxt  = 2'd1;
        need_nxt = len;
      end
    end
    if (end_of_stream) begin
      cnt_nxt  = 2'd0;
      need_nxt = 3'd0;
    end
  end

  // Sequence counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      need_r <= 3'd0;
    end else if (accept) begin
      cnt_r  <= cnt_nxt;
      need_r <= need_nxt;
    end
  end

  // Held bytes; only entries written in the current sequence are ever read.
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      pend_r[wr_idx] <= data_byte;
    end
  end

endmodule

### rtl/usan_emit.sv
// Byte emitter: a small sequencer emitting a plan one output byte per cycle unless stalled.
module usan_emit
  import usan_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  usan_plan_t plan,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       accept,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       stream_done
);

  em_state_t       state_r, state_nxt;
  logic [2:0]      rep_r, rep_nxt;
  logic [1:0]      sub_r, sub_nxt;
  logic [1:0]      held_n_r, held_n_nxt;
  logic [1:0]      idx_r, idx_nxt;
  logic            tail_r, tail_nxt;
  logic [7:0]      tail_byte_r, tail_byte_nxt;
  logic [2:0][7:0] held_r, held_nxt;
  logic            eos_r, eos_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_byte_r, out_byte_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_done_r, out_done_nxt;

  logic       out_ok;
  logic       step;
  logic [7:0] cur_byte;
  logic [2:0] rep_step;
  logic [1:0] sub_step;
  logic [1:0] held_n_step;
  logic [1:0] idx_step;
  logic       tail_step;
  logic       done_now;
  logic       plan_empty;

  // Shared step unit: picks the current byte and advances the counters.
  always_comb begin
    rep_step    = rep_r;
    sub_step    = sub_r;
    held_n_step = held_n_r;
    idx_step    = idx_r;
    tail_step   = tail_r;
    if (rep_r != 3'd0) begin
      cur_byte = rep_byte(sub_r);
      if (sub_r == 2'd2) begin
        sub_step = 2'd0;
        rep_step = rep_r - 3'd1;
      end else begin
        sub_step = sub_r + 2'd1;
      end
    end else if (held_n_r != 2'd0) begin
      cur_byte    = held_r[idx_r];
      idx_step    = idx_r + 2'd1;
      held_n_step = held_n_r - 2'd1;
    end else begin
      cur_byte  = tail_byte_r;
      tail_step = 1'b0;
    end
    done_now = (rep_step == 3'd0) && (held_n_step == 2'd0) && !tail_step;
  end

  // Handshake: a new request is taken when idle or as the last byte of the current one leaves.
  always_comb begin
    out_ok     = !out_valid_r || out_ready;
    step       = (state_r == EM_RUN) && out_ok;
    in_ready   = (state_r == EM_IDLE) || (step && done_now);
    accept     = in_valid && in_ready;
    plan_empty = (plan.rep_n == 3'd0) && (plan.held_n == 2'd0) && !plan.tail;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      EM_IDLE: begin
        if (accept && !plan_empty) begin
          state_nxt = EM_RUN;
        end
      end
      EM_RUN: begin
        if (step && done_now) begin
          state_nxt = (accept && !plan_empty) ? EM_RUN : EM_IDLE;
        end
      end
      default: state_nxt = EM_IDLE;
    endcase
  end

  // Counters, plan registers and the output register.
  always_comb begin
    rep_nxt       = rep_r;
    sub_nxt       = sub_r;
    held_n_nxt    = held_n_r;
    idx_nxt       = idx_r;
    tail_nxt      = tail_r;
    tail_byte_nxt = tail_byte_r;
    held_nxt      = held_r;
    eos_nxt       = eos_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    if (step) begin
      rep_nxt    = rep_step;
      sub_nxt    = sub_step;
      held_n_nxt = held_n_step;
      idx_nxt    = idx_step;
      tail_nxt   = tail_step;
    end
    if (accept) begin
      rep_nxt       = plan.rep_n;
      sub_nxt       = 2'd0;
      held_n_nxt    = plan.held_n;
      idx_nxt       = 2'd0;
      tail_nxt      = plan.tail;
      tail_byte_nxt = plan.tail_byte;
      held_nxt      = plan.held;
      eos_nxt       = plan.eos;
    end
    if (out_ok) begin
      out_valid_nxt = step;
      out_byte_nxt  = cur_byte;
      out_last_nxt  = done_now;
      out_done_nxt  = done_now && eos_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= EM_IDLE;
      rep_r       <= 3'd0;
      sub_r       <= 2'd0;
      held_n_r    <= 2'd0;
      idx_r       <= 2'd0;
      tail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rep_r       <= rep_nxt;
      sub_r       <= sub_nxt;
      held_n_r    <= held_n_nxt;
      idx_r       <= idx_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    tail_byte_r <= tail_byte_nxt;
    held_r      <= held_nxt;
    eos_r       <= eos_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    out_done_r  <= out_done_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign last_of_run = out_last_r;
  assign stream_done = out_done_r;

endmodule

### rtl/utf8_sanitizer_top.sv
// UTF-8 sanitiser top level: sequence tracker and byte emitter.
//
// Raw bytes enter on in_ch (valid/ready) with an end-of-stream flag; cleaned
// UTF-8 bytes leave on out_ch (valid/ready). Malformed bytes become U+FFFD.
// Each accepted request causes 0 to 12 output bytes. Its plan is first
// registered in the emitter, and its bytes then pass through the output
// register, one byte per cycle while out_ch is ready. The emitter sequencer
// walks each request's plan a byte at a time. A new request is taken in the
// same cycle as the final byte of the previous one is registered, so plain
// ASCII text flows at one byte per cycle while out_ch is ready.
// The last byte of each request carries last_of_run; the last byte of a
// stream carries stream_done as well, and the open sequence is then cleared.
// Reset clears any open sequence and empties the output register. When the
// receiver stalls, the output byte holds and no further request is taken
// once the emitter has a byte it cannot register.
module utf8_sanitizer_top
  import usan_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  usan_in_if.sink    in_ch,
  usan_out_if.source out_ch
);

  usan_plan_t plan;
  logic       accept;

  usan_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .data_byte     (in_ch.data_byte),
    .end_of_stream (in_ch.end_of_stream),
    .plan          (plan)
  );

  usan_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .plan        (plan),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .accept      (accept),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_byte    (out_ch.out_byte),
    .last_of_run (out_ch.last_of_run),
    .stream_done (out_ch.stream_done)
  );

endmodule

### rtl/usan_checker.sv
// Port-level checks on the UTF-8 sanitiser, bound to the top level.
module usan_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       out_done
);

  // The end of a stream is always the end of a request.
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done |-> out_last)
    else $error("stream_done without last_of_run");

  // A stalled output byte holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("output byte changed under stall");

  // While a request still has bytes waiting behind a stalled output, no new request is taken.
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && !out_last |-> !in_ready)
    else $error("input taken while a request is unfinished");

  // Reset leaves the output empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind utf8_sanitizer_top usan_checker u_usan_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.last_of_run),
  .out_done  (out_ch.stream_done)
);

### bench/usan_stream_checker.sv
// Checker that predicts the sanitised byte stream and compares it with the output channel.
`timescale 1ns / 100ps

module usan_stream_checker
  import usan_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_eos,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_last,
  input  logic       out_done,
  output int         fail_count,
  output int         expected_left,
  output int         bytes_checked,
  output int         reps_predicted
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       done;
  } clean_byte_t;

  // Predicted bytes still to appear on the output, oldest first.
  clean_byte_t clean_q[$];
  // Bytes caused by the request being predicted.
  clean_byte_t run_q[$];

  // Predictor copy of the open sequence.
  logic [7:0] held [3];
  logic [1:0] held_n;
  logic [2:0] seq_len;

  // Length of the sequence a lead byte opens, zero for anything else.
  function automatic logic [2:0] lead_span(input logic [7:0] b);
    casez (b)
      8'b110?????: return 3'd2;
      8'b1110????: return 3'd3;
      8'b11110???: return 3'd4;
      default:     return 3'd0;
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b);
    run_q.insert(run_q.size(), {b, 1'b0, 1'b0});
  endtask

  task automatic push_rep();
    push_byte(REP_BYTE0);
    push_byte(REP_BYTE1);
    push_byte(REP_BYTE2);
    reps_predicted++;
  endtask

  task automatic close_sequence();
    held_n  = 2'd0;
    seq_len = 3'd0;
  endtask

  // A byte seen with no sequence open.
  task automatic take_fresh(input logic [7:0] b, input logic eos);
    logic [2:0] span;
    span = lead_span(b);
    if (!b[7]) begin
      push_byte(b);
    end else if (span == 3'd0 || eos) begin
      push_rep();
    end else begin
      held[0] = b;
      held_n  = 2'd1;
      seq_len = span;
    end
  endtask

  // A byte seen while a sequence is open.
  task automatic take_open(input logic [7:0] b, input logic eos);
    int k;
    if (b[7:6] == 2'b10) begin
      if (int'(held_n) + 1 >= int'(seq_len)) begin
        for (k = 0; k < int'(held_n); k++) push_byte(held[k]);
        push_byte(b);
        close_sequence();
      end else if (eos) begin
        push_rep();
        close_sequence();
      end else begin
        held[held_n] = b;
        held_n       = held_n + 2'd1;
      end
    end else begin
      // The lead and every held continuation byte each become a replacement.
      for (k = 0; k < int'(held_n); k++) push_rep();
      close_sequence();
      take_fresh(b, eos);
    end
  endtask

  // Work out every byte that one request causes and queue them.
  task automatic sanitise(input logic [7:0] b, input logic eos);
    clean_byte_t tail;
    int          idx;
    run_q.delete();
    if (held_n == 2'd0 || seq_len < 3'd2 || seq_len > 3'd4) begin
      close_sequence();
      take_fresh(b, eos);
    end else begin
      take_open(b, eos);
    end
    if (eos) close_sequence();
    if (run_q.size() > 0) begin
      idx        = run_q.size() - 1;
      tail       = run_q[idx];
      tail.last  = 1'b1;
      tail.done  = eos;
      run_q[idx] = tail;
    end
    foreach (run_q[i]) clean_q.insert(clean_q.size(), run_q[i]);
  endtask

  task automatic note_failure(input string what);
    if (fail_count < REPORT_LIMIT) $display("%0t: %s", $realtime, what);
    fail_count++;
  endtask

  // Compare first, then predict: no output byte belongs to a request taken at the same edge.
  always @(posedge clk) begin
    clean_byte_t want;
    if (!rst_n) begin
      clean_q.delete();
      close_sequence();
      fail_count     = 0;
      bytes_checked  = 0;
      reps_predicted = 0;
      expected_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        bytes_checked++;
        if (clean_q.size() == 0) begin
          note_failure($sformatf("unexpected output byte %h last %b done %b",
                                 out_byte, out_last, out_done));
        end else begin
          want = clean_q[0];
          clean_q.delete(0);
          if (out_byte !== want.value || out_last !== want.last || out_done !== want.done) begin
            note_failure($sformatf("mismatch: got byte %h last %b done %b, wanted %h %b %b",
                                   out_byte, out_last, out_done,
                                   want.value, want.last, want.done));
          end
        end
      end
      if (in_valid && in_ready) sanitise(in_byte, in_eos);
      expected_left <= clean_q.size();
    end
  end

endmodule

### bench/utf8_sanitizer_top_test.sv
// Top of the UTF-8 sanitiser testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module utf8_sanitizer_top_test;

  localparam int RANDOM_ITEMS = 104;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 16;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic idling_on = 1'b1;

  int fails;
  int expected_left;
  int bytes_checked;
  int reps_predicted;
  int requests_sent = 0;
  int streams_sent  = 0;
  int quiet_cycles  = 0;

  usan_in_if  in_ch();
  usan_out_if out_ch();

  utf8_sanitizer_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  usan_stream_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_byte        (in_ch.data_byte),
    .in_eos         (in_ch.end_of_stream),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_byte       (out_ch.out_byte),
    .out_last       (out_ch.last_of_run),
    .out_done       (out_ch.stream_done),
    .fail_count     (fails),
    .expected_left  (expected_left),
    .bytes_checked  (bytes_checked),
    .reps_predicted (reps_predicted)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The receiver stalls in about seven percent of cycles while idling is on.
  always @(posedge clk) begin
    out_ch.ready <= !idling_on || ($urandom_range(99) >= 7);
  end

  // Give up if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no traffic for %0d cycles, %0d bytes still expected",
               quiet_cycles, expected_left);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one request, with random gaps in front of it, and wait for its acceptance.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    while (idling_on && $urandom_range(99) < 7) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= b;
    in_ch.end_of_stream <= eos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    requests_sent++;
    if (eos) streams_sent++;
  endtask

  // Stop sending and wait until every predicted byte has come out.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] random_lead(input int span);
    case (span)
      2:       return 8'($urandom_range(8'hC0, 8'hDF));
      3:       return 8'($urandom_range(8'hE0, 8'hEF));
      default: return 8'($urandom_range(8'hF0, 8'hF7));
    endcase
  endfunction

  // Mostly well-formed characters with random content, the rest broken sequences and noise.
  task automatic send_random_text(input int count);
    logic [7:0] frag[$];
    logic [7:0] b;
    int         sent;
    int         pick;
    int         span;
    int         conts;
    sent = 0;
    while (sent < count) begin
      // A quiet stretch through the middle third of the run.
      idling_on <= !(sent >= count / 3 && sent < 2 * count / 3);
      frag.delete();
      pick = $urandom_range(99);
      span = $urandom_range(1, 4);
      if (span == 1 && pick < 88) begin
        frag.insert(frag.size(), 8'($urandom_range(8'h7F)));
      end else if (pick < 70) begin
        frag.insert(frag.size(), random_lead(span));
        repeat (span - 1) frag.insert(frag.size(), 8'($urandom_range(8'h80, 8'hBF)));
      end else if (pick < 88) begin
        frag.insert(frag.size(), random_lead(span));
        conts = $urandom_range(0, span - 2);
        repeat (conts) frag.insert(frag.size(), 8'($urandom_range(8'h80, 8'hBF)));
        do begin
          b = 8'($urandom_range(255));
        end while (b[7:6] == 2'b10);
        frag.insert(frag.size(), b);
      end else begin
        frag.insert(frag.size(), 8'($urandom_range(255)));
      end
      // End of stream may fall anywhere, cutting a sequence off.
      foreach (frag[i]) begin
        send_byte(frag[i], $urandom_range(24) == 0);
        sent++;
      end
    end
    send_byte(8'($urandom_range(8'h7F)), 1'b1);
  endtask

  initial begin
    in_ch.valid         <= 1'b0;
    in_ch.data_byte     <= 8'h00;
    in_ch.end_of_stream <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Plain ASCII extremes, a stray continuation byte and an invalid byte.
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF8, 1'b0);
    // Complete two, three and four byte characters.
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    // Bad continuation after three held bytes: the widest burst of replacements.
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'hFF, 1'b0);
    // Bad continuation that is itself a lead byte opening a new sequence.
    send_byte(8'hE2, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    // Sequence cut off by the end of the stream, then a lead byte as the final byte.
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b1);
    send_byte(8'hE2, 1'b1);
    // Bad continuation by a plain byte that ends the stream.
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b1);

    // Hold the sender back until the output has caught up completely.
    wait_drained();

    send_random_text(RANDOM_ITEMS);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests in %0d streams; checked %0d output bytes, %0d replacements.",
             requests_sent, streams_sent, bytes_checked, reps_predicted);
    $display("Failures counted: %0d, bytes still expected: %0d", fails, expected_left);
    if (fails == 0 && expected_left == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
